### hdl/pnr_pkg.sv
package pnr_pkg;

    localparam int XW  = 10;
    localparam int YW  = 9;
    localparam int BCW = XW - 1;

    localparam int CQ_DEPTH = 4;
    localparam int CQ_AW    = 2;

    localparam logic [2:0] CMD_WRITE = 3'd0;
    localparam logic [2:0] CMD_READ  = 3'd1;
    localparam logic [2:0] CMD_FILL  = 3'd2;
    localparam logic [2:0] CMD_GLYPH = 3'd3;
    localparam logic [2:0] CMD_FONT  = 3'd4;

    typedef logic [1:0] t_op;

    localparam t_op OP_RECT  = 2'd0;
    localparam t_op OP_GLYPH = 2'd1;
    localparam t_op OP_READ  = 2'd2;
    localparam t_op OP_FONT  = 2'd3;

    typedef struct packed {
        t_op             op;
        logic [XW-1:0]   x0;
        logic [YW-1:0]   y0;
        logic [XW-1:0]   x1;
        logic [YW-1:0]   y1;
        logic [3:0]      color;
        logic            flag;
        logic [7:0]      code;
        logic            dbl;
        logic [11:0]     faddr;
        logic [7:0]      fdata;
    } t_cmd;

endpackage

### hdl/pnr_front.sv
module pnr_front #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int GLYPH_COUNT   = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [2:0]    i_cmd,
    input  logic [8:0]    i_x,
    input  logic [7:0]    i_y,
    input  logic [8:0]    i_x_end,
    input  logic [7:0]    i_y_end,
    input  logic [3:0]    i_color,
    input  logic [7:0]    i_glyph_code,
    input  logic          i_double_size,
    input  logic [11:0]   i_font_addr,
    input  logic [7:0]    i_font_data,
    input  logic          i_clearing,
    output pnr_pkg::t_cmd o_cmd,
    output logic          o_valid,
    input  logic          i_take
);
    import pnr_pkg::*;

    localparam int FONT_BYTES = GLYPH_COUNT * 16;

    t_cmd              r_q [CQ_DEPTH];
    logic [CQ_AW-1:0]  r_wp, n_wp;
    logic [CQ_AW-1:0]  r_rp, n_rp;
    logic [CQ_AW:0]    r_cnt, n_cnt;

    t_cmd              w_cls;
    logic              w_keep;
    logic [XW-1:0]     w_x1_raw;
    logic [YW-1:0]     w_y1_raw;
    logic [XW-1:0]     w_x1;
    logic [YW-1:0]     w_y1;
    logic              w_wr;
    logic              w_rd;

    always_comb begin
        w_x1_raw = XW'(i_x) + XW'(1);
        w_y1_raw = YW'(i_y) + YW'(1);
        case (i_cmd)
            CMD_FILL: begin
                w_x1_raw = XW'(i_x_end);
                w_y1_raw = YW'(i_y_end);
            end
            CMD_GLYPH: begin
                w_x1_raw = XW'(i_x) + (i_double_size ? XW'(16) : XW'(8));
                w_y1_raw = YW'(i_y) + (i_double_size ? YW'(32) : YW'(16));
            end
            default: begin
                w_x1_raw = XW'(i_x) + XW'(1);
                w_y1_raw = YW'(i_y) + YW'(1);
            end
        endcase
        w_x1 = (32'(w_x1_raw) < SCREEN_WIDTH)  ? w_x1_raw : XW'(SCREEN_WIDTH);
        w_y1 = (32'(w_y1_raw) < SCREEN_HEIGHT) ? w_y1_raw : YW'(SCREEN_HEIGHT);

        w_cls.op    = OP_RECT;
        w_cls.x0    = XW'(i_x);
        w_cls.y0    = YW'(i_y);
        w_cls.x1    = w_x1;
        w_cls.y1    = w_y1;
        w_cls.color = i_color;
        w_cls.flag  = 1'b0;
        w_cls.code  = i_glyph_code;
        w_cls.dbl   = i_double_size;
        w_cls.faddr = i_font_addr;
        w_cls.fdata = i_font_data;
        w_keep      = 1'b0;
        case (i_cmd)
            CMD_WRITE, CMD_FILL: begin
                w_keep = (w_x1 > XW'(i_x)) && (w_y1 > YW'(i_y));
            end
            CMD_GLYPH: begin
                w_cls.op   = OP_GLYPH;
                w_cls.flag = 32'(i_glyph_code) < GLYPH_COUNT;
                w_keep     = (w_x1 > XW'(i_x)) && (w_y1 > YW'(i_y));
            end
            CMD_READ: begin
                w_cls.op   = OP_READ;
                w_cls.flag = (32'(i_x) < SCREEN_WIDTH) && (32'(i_y) < SCREEN_HEIGHT);
                w_keep     = 1'b1;
            end
            CMD_FONT: begin
                w_cls.op = OP_FONT;
                w_keep   = 32'(i_font_addr) < FONT_BYTES;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_full  = (r_cnt == (CQ_AW+1)'(CQ_DEPTH)) || i_clearing;
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_q[r_rp];
    assign w_wr    = i_push && !o_full && w_keep;
    assign w_rd    = i_take && o_valid;

    always_comb begin
        n_wp  = w_wr ? r_wp + CQ_AW'(1) : r_wp;
        n_rp  = w_rd ? r_rp + CQ_AW'(1) : r_rp;
        n_cnt = r_cnt + (CQ_AW+1)'(w_wr) - (CQ_AW+1)'(w_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= w_cls;
        end
    end

endmodule

### hdl/pnr_back.sv
module pnr_back #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int GLYPH_COUNT   = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pnr_pkg::t_cmd i_cmd,
    input  logic          i_cmd_valid,
    output logic          o_cmd_take,
    input  logic          i_res_full,
    output logic          o_res_push,
    output logic [3:0]    o_res_value,
    input  logic          i_cfg_we,
    input  logic [3:0]    i_cfg_data,
    output logic          o_clearing
);
    import pnr_pkg::*;

    localparam int ROW_BYTES   = (SCREEN_WIDTH + 1) / 2;
    localparam int FRAME_DEPTH = ROW_BYTES * SCREEN_HEIGHT;
    localparam int FAW         = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int FONT_DEPTH  = GLYPH_COUNT * 16;
    localparam int FONT_AW     = $clog2(FONT_DEPTH);

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_SETUP   = 3'd2;
    localparam logic [2:0] S_ROW     = 3'd3;
    localparam logic [2:0] S_COL     = 3'd4;
    localparam logic [2:0] S_RD      = 3'd5;
    localparam logic [2:0] S_RD_DONE = 3'd6;

    logic [3:0] r_hi_mem   [FRAME_DEPTH];
    logic [3:0] r_lo_mem   [FRAME_DEPTH];
    logic [7:0] r_font_mem [FONT_DEPTH];

    logic [2:0]       r_state, n_state;
    logic [FAW-1:0]   r_clr_addr, n_clr_addr;
    t_cmd             r_cur, n_cur;
    logic [FAW-1:0]   r_row_base, n_row_base;
    logic [YW-1:0]    r_py, n_py;
    logic [BCW-1:0]   r_bc, n_bc;
    logic [BCW-1:0]   r_bc_end, n_bc_end;
    logic [7:0]       r_font_q;
    logic [3:0]       r_rd_hi;
    logic [3:0]       r_rd_lo;
    logic [3:0]       r_bg;

    logic [XW-1:0]    w_px_e;
    logic [XW-1:0]    w_px_o;
    logic             w_in_e;
    logic             w_in_o;
    logic [YW-1:0]    w_line;
    logic [3:0]       w_frow;
    logic [7:0]       w_bits;
    logic [FAW-1:0]   w_addr;
    logic [FAW-1:0]   w_mem_addr;
    logic             w_we_hi;
    logic             w_we_lo;
    logic [3:0]       w_d_hi;
    logic [3:0]       w_d_lo;
    logic             w_font_we;
    logic [FONT_AW-1:0] w_font_rd_addr;

    function automatic logic [3:0] f_color(input logic [XW-1:0] px, input t_cmd cur,
                                           input logic [7:0] bits, input logic [3:0] bg);
        logic [XW-1:0] col;
        logic [2:0]    idx;
        col = px - cur.x0;
        idx = cur.dbl ? col[3:1] : col[2:0];
        if (cur.op == OP_GLYPH) begin
            return bits[3'd7 - idx] ? cur.color : bg;
        end
        return cur.color;
    endfunction

    always_comb begin
        w_px_e         = {r_bc, 1'b0};
        w_px_o         = {r_bc, 1'b1};
        w_in_e         = (w_px_e >= r_cur.x0) && (w_px_e < r_cur.x1);
        w_in_o         = (w_px_o >= r_cur.x0) && (w_px_o < r_cur.x1);
        w_line         = r_py - r_cur.y0;
        w_frow         = r_cur.dbl ? w_line[4:1] : w_line[3:0];
        w_bits         = r_cur.flag ? r_font_q : 8'h00;
        w_addr         = r_row_base + FAW'(r_bc);
        w_font_rd_addr = FONT_AW'({r_cur.code, w_frow});
        w_font_we      = (r_state == S_IDLE) && i_cmd_valid && (i_cmd.op == OP_FONT);

        w_mem_addr = w_addr;
        w_we_hi    = 1'b0;
        w_we_lo    = 1'b0;
        w_d_hi     = f_color(w_px_e, r_cur, w_bits, r_bg);
        w_d_lo     = f_color(w_px_o, r_cur, w_bits, r_bg);
        case (r_state)
            S_CLEAR: begin
                w_mem_addr = r_clr_addr;
                w_we_hi    = 1'b1;
                w_we_lo    = 1'b1;
                w_d_hi     = 4'h0;
                w_d_lo     = 4'h0;
            end
            S_COL: begin
                w_we_hi = w_in_e;
                w_we_lo = w_in_o;
            end
            default: begin
                w_we_hi = 1'b0;
                w_we_lo = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_cur      = r_cur;
        n_row_base = r_row_base;
        n_py       = r_py;
        n_bc       = r_bc;
        n_bc_end   = r_bc_end;
        o_cmd_take = 1'b0;
        case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + FAW'(1);
                if (r_clr_addr == FAW'(FRAME_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        OP_FONT: begin
                            o_cmd_take = 1'b1;
                        end
                        OP_READ: begin
                            if (!i_res_full) begin
                                o_cmd_take = 1'b1;
                                n_cur      = i_cmd;
                                n_state    = S_SETUP;
                            end
                        end
                        default: begin
                            o_cmd_take = 1'b1;
                            n_cur      = i_cmd;
                            n_state    = S_SETUP;
                        end
                    endcase
                end
            end
            S_SETUP: begin
                n_row_base = FAW'(32'(r_cur.y0) * ROW_BYTES);
                n_py       = r_cur.y0;
                n_bc       = BCW'(r_cur.x0 >> 1);
                n_bc_end   = BCW'((r_cur.x1 - XW'(1)) >> 1);
                n_state    = (r_cur.op == OP_READ) ? S_RD : S_ROW;
            end
            S_ROW: begin
                n_bc    = BCW'(r_cur.x0 >> 1);
                n_state = S_COL;
            end
            S_COL: begin
                if (r_bc == r_bc_end) begin
                    if (YW'(r_py + YW'(1)) == r_cur.y1) begin
                        n_state = S_IDLE;
                    end else begin
                        n_py       = r_py + YW'(1);
                        n_row_base = r_row_base + FAW'(ROW_BYTES);
                        n_state    = S_ROW;
                    end
                end else begin
                    n_bc = r_bc + BCW'(1);
                end
            end
            S_RD: begin
                n_state = S_RD_DONE;
            end
            S_RD_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res_push  = r_state == S_RD_DONE;
    assign o_res_value = !r_cur.flag ? 4'h0 : (r_cur.x0[0] ? r_rd_lo : r_rd_hi);
    assign o_clearing  = r_state == S_CLEAR;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_bg       <= 4'h0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            if (i_cfg_we) begin
                r_bg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_row_base <= n_row_base;
        r_py       <= n_py;
        r_bc       <= n_bc;
        r_bc_end   <= n_bc_end;
    end

    always_ff @(posedge i_clk) begin
        if (w_we_hi) begin
            r_hi_mem[w_mem_addr] <= w_d_hi;
        end
        if (w_we_lo) begin
            r_lo_mem[w_mem_addr] <= w_d_lo;
        end
        r_rd_hi <= r_hi_mem[w_mem_addr];
        r_rd_lo <= r_lo_mem[w_mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_font_we) begin
            r_font_mem[FONT_AW'(i_cmd.faddr)] <= i_cmd.fdata;
        end
        if (r_state == S_ROW) begin
            r_font_q <= r_font_mem[w_font_rd_addr];
        end
    end

endmodule

### hdl/pnr_resq.sv
module pnr_resq (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [3:0] i_data,
    output logic       o_full,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [3:0] o_data
);
    logic [3:0] r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       w_wr;
    logic       w_rd;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_comb begin
        n_cnt = r_cnt + 2'(w_wr) - 2'(w_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= r_wp ^ w_wr;
            r_rp  <= r_rp ^ w_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### hdl/packed_nibble_raster_engine_top.sv
// 4-bit-per-pixel framebuffer engine, two pixels per byte, even x in the high nibble.
// Commands enter a four-deep queue and run one at a time against a frame store that
// moves one byte (two pixels) per cycle. From the head of the queue a font load is
// written from idle; a pixel write passes setup, row and column states; a pixel read
// passes setup, read and read-done; a fill runs setup, then per row a row state and
// one column state per byte column, clipped to the screen; a glyph runs alike over
// 16 rows (32 at double size), one byte column fewer per row for an even x. After
// reset, with full held high, the frame store is zeroed one byte per cycle over its
// ((SCREEN_WIDTH + 1) / 2) * SCREEN_HEIGHT bytes (38400 at 320 x 240); background
// writes are taken during that pass. Only read pixel commands produce a result beat;
// unknown commands, empty fills and off-screen writes are taken and dropped.
module packed_nibble_raster_engine_top #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int GLYPH_COUNT   = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_cmd,
    input  logic [8:0]  i_x,
    input  logic [7:0]  i_y,
    input  logic [8:0]  i_x_end,
    input  logic [7:0]  i_y_end,
    input  logic [3:0]  i_color,
    input  logic [7:0]  i_glyph_code,
    input  logic        i_double_size,
    input  logic [11:0] i_font_addr,
    input  logic [7:0]  i_font_data,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_pixel_value,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data
);
    import pnr_pkg::*;

    t_cmd       w_cmd;
    logic       w_cmd_valid;
    logic       w_cmd_take;
    logic       w_clearing;
    logic       w_res_full;
    logic       w_res_push;
    logic [3:0] w_res_value;

    pnr_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .GLYPH_COUNT   (GLYPH_COUNT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_cmd         (i_cmd),
        .i_x           (i_x),
        .i_y           (i_y),
        .i_x_end       (i_x_end),
        .i_y_end       (i_y_end),
        .i_color       (i_color),
        .i_glyph_code  (i_glyph_code),
        .i_double_size (i_double_size),
        .i_font_addr   (i_font_addr),
        .i_font_data   (i_font_data),
        .i_clearing    (w_clearing),
        .o_cmd         (w_cmd),
        .o_valid       (w_cmd_valid),
        .i_take        (w_cmd_take)
    );

    pnr_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .GLYPH_COUNT   (GLYPH_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_take  (w_cmd_take),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res_value (w_res_value),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_clearing  (w_clearing)
    );

    pnr_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_value),
        .o_full  (w_res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (o_pixel_value)
    );

endmodule

### hdl/pnr_checker.sv
module pnr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [3:0] o_pixel_value
);

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result beat present right after reset");

    a_rst_full: assert property (@(posedge i_clk) !i_rst_n |=> full)
        else $error("input open during frame clear");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_pixel_value)))
        else $error("waiting result beat changed or vanished");

endmodule

bind packed_nibble_raster_engine_top pnr_checker u_pnr_checker (.*);
